// ===== design/pwlcm_pkg.sv =====
// shared widths and codes of the piecewise linear color map
package pwlcm_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int COLOR_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CHAN_W      = 8;

   // command codes of an input word
   localparam logic CMD_COLORIZE    = 1'b0;
   localparam logic CMD_WRITE_POINT = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NAN_COLOR   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_COUNT = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_BLEND = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

endpackage

// ===== design/pwlcm_ifs.sv =====
// request and response channel interfaces of the piecewise linear color map
interface pwlcm_req_if
   import pwlcm_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       sample_is_nan;
   logic [INDEX_W-1:0]         point_index;
   logic signed [SAMPLE_W-1:0] point_key;
   logic [COLOR_W-1:0]         point_color;

   modport source (
      output valid, command, sample, sample_is_nan, point_index, point_key, point_color,
      input  ready
   );
   modport sink (
      input  valid, command, sample, sample_is_nan, point_index, point_key, point_color,
      output ready
   );
endinterface

interface pwlcm_rsp_if
   import pwlcm_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] color;

   modport source (output valid, color, input ready);
   modport sink (input valid, color, output ready);
endinterface

// ===== design/pwlcm_ram.sv =====
// generic single write port ram with registered read
module pwlcm_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/piecewise_linear_color_map.sv =====
// top level of the piecewise linear color map: search, divide and blend over a point ram
//
// usage
//   req_item carries one word per command. a write-point word stores key and color
//   in the point ram in the cycle it is accepted and gives no response word.
//   a colorize word gives exactly one response word on rsp_item.
//   csr_wr_en/csr_index/csr_data write nan_color (index 0) and point_count (index 1);
//   write them only while the block is idle.
// sequence and throughput
//   one colorize word is in flight at a time. nan samples and the gray ramp go
//   from the result register to the response register. an interpolated sample
//   passes key search (up to n ram reads, one per cycle, n = point_count
//   clamped to MAX_POINTS), the restoring divider, blending (one channel
//   multiply per cycle) and the load of the response register.
//   a write-point word leaves the controller idle, ready for the next word.
// reset and stall
//   reset clears the controller, the response valid flag, nan_color and point_count.
//   the point ram is not cleared; slots must be written before they are used.
//   the response register holds a word until rsp_item.ready; the block still takes
//   the next request, and the controller waits for the register before loading it.
module piecewise_linear_color_map
   import pwlcm_pkg::*;
#(
   parameter int MAX_POINTS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   pwlcm_req_if.sink              req_item,
   pwlcm_rsp_if.source            rsp_item,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data
);

   localparam int AW      = $clog2(MAX_POINTS);
   localparam int CW      = $clog2(MAX_POINTS + 1);
   localparam int IW      = (AW > INDEX_W) ? AW : INDEX_W;
   localparam int ENTRY_W = SAMPLE_W + COLOR_W;
   localparam int QCW     = $clog2(FRAC_BITS + 1);
   localparam int DIFF_W  = SAMPLE_W + 1;
   localparam int GW      = (FRAC_BITS + 2 > SAMPLE_W + 1) ? FRAC_BITS + 2 : SAMPLE_W + 1;
   localparam int PROD_W  = FRAC_BITS + 11;

   localparam logic signed [GW-1:0] ONE_G   = GW'(64'd1 << FRAC_BITS);
   localparam logic [FRAC_BITS:0]   REL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // control and configuration registers
   state_type                  state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]         rsp_color_ff, rsp_color_in;
   logic [COLOR_W-1:0]         nan_color_ff, nan_color_in;
   logic [COUNT_W-1:0]         point_count_ff, point_count_in;

   // search, divide and blend datapath
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [CW-1:0]              issue_ff, issue_in;
   logic                       dv_ff, dv_in;
   logic [AW-1:0]              chk_idx_ff, chk_idx_in;
   logic signed [SAMPLE_W-1:0] prev_key_ff, prev_key_in;
   logic [COLOR_W-1:0]         prev_col_ff, prev_col_in;
   logic [COLOR_W-1:0]         hi_col_ff, hi_col_in;
   logic [SAMPLE_W-1:0]        dk_ff, dk_in;
   logic [SAMPLE_W-1:0]        rem_ff, rem_in;
   logic [FRAC_BITS-1:0]       quo_ff, quo_in;
   logic [QCW-1:0]             qcnt_ff, qcnt_in;
   logic [FRAC_BITS:0]         rel_ff, rel_in;
   logic [1:0]                 ch_ff, ch_in;
   logic [COLOR_W-1:0]         res_ff, res_in;

   // point ram ports
   logic                       wr_en;
   logic [IW-1:0]              wr_idx;
   logic [ENTRY_W-1:0]         wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [ENTRY_W-1:0]         rd_data;
   logic signed [SAMPLE_W-1:0] rd_key;
   logic [COLOR_W-1:0]         rd_col;

   logic                       accept_req;
   logic                       out_free;
   logic [CW-1:0]              n_use;
   logic [CW-1:0]              n_last;

   // gray ramp
   logic [FRAC_BITS:0]         gray_c;
   logic [FRAC_BITS+8:0]       gray_prod;
   logic [CHAN_W-1:0]          gray_v;
   logic [COLOR_W-1:0]         gray_color;

   // search and divider step
   logic signed [DIFF_W-1:0]   dx;
   logic signed [DIFF_W-1:0]   dk_s;
   logic [SAMPLE_W:0]          rem_2x;
   logic                       q_bit;
   logic [FRAC_BITS-1:0]       quo_next;

   // blend of one channel
   logic [CHAN_W-1:0]          chan_a;
   logic [CHAN_W-1:0]          chan_b;
   logic signed [CHAN_W:0]     chan_diff;
   logic signed [PROD_W-1:0]   chan_prod;
   logic signed [PROD_W-1:0]   chan_sh;
   logic [CHAN_W+1:0]          chan_sum;

   assign accept_req     = req_item.valid && req_item.ready;
   assign req_item.ready = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_item.ready;
   assign rsp_item.valid = rsp_valid_ff;
   assign rsp_item.color = rsp_color_ff;

   // count above the table depth behaves as a full table
   always_comb begin
      if (9'(point_count_ff) > 9'(MAX_POINTS)) begin
         n_use = CW'(MAX_POINTS);
      end else begin
         n_use = CW'(point_count_ff);
      end
   end
   assign n_last = n_use - CW'(1);

   // point writes go straight into the ram, out-of-table slots are dropped
   assign wr_idx  = IW'(req_item.point_index);
   assign wr_en   = accept_req && (req_item.command == CMD_WRITE_POINT) &&
                    ({5'b0, req_item.point_index} < 9'(MAX_POINTS));
   assign wr_data = {req_item.point_key, req_item.point_color};

   // one key read per cycle while scanning
   assign rd_en   = (state_ff == ST_SCAN) && (issue_ff < n_use);
   assign rd_addr = issue_ff[AW-1:0];
   assign rd_key  = signed'(rd_data[ENTRY_W-1:COLOR_W]);
   assign rd_col  = rd_data[COLOR_W-1:0];

   pwlcm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // gray ramp: clamp to [0, 1.0], then floor(x * 255)
   always_comb begin
      if (req_item.sample < 0) begin
         gray_c = '0;
      end else if (GW'(req_item.sample) > ONE_G) begin
         gray_c = REL_ONE;
      end else begin
         gray_c = (FRAC_BITS + 1)'(req_item.sample);
      end
      gray_prod  = ((FRAC_BITS + 9)'(gray_c) << 8) - (FRAC_BITS + 9)'(gray_c);
      gray_v     = gray_prod[FRAC_BITS +: CHAN_W];
      gray_color = {8'hFF, gray_v, gray_v, gray_v};
   end

   // interval width and offset against the point below
   assign dx   = DIFF_W'(x_ff) - DIFF_W'(prev_key_ff);
   assign dk_s = DIFF_W'(rd_key) - DIFF_W'(prev_key_ff);

   // restoring divider step, remainder always below the divisor
   assign rem_2x   = {rem_ff, 1'b0};
   assign q_bit    = (rem_2x >= {1'b0, dk_ff});
   assign quo_next = {quo_ff[FRAC_BITS-2:0], q_bit};

   // c1 + floor((c2 - c1) * rel / 1.0) equals the weighted floor of both colors
   assign chan_a    = prev_col_ff[{ch_ff, 3'b000} +: CHAN_W];
   assign chan_b    = hi_col_ff[{ch_ff, 3'b000} +: CHAN_W];
   assign chan_diff = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
   assign chan_prod = PROD_W'(chan_diff) * PROD_W'($signed({1'b0, rel_ff}));
   assign chan_sh   = chan_prod >>> FRAC_BITS;
   assign chan_sum  = chan_sh[CHAN_W+1:0] + {2'b00, chan_a};

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_item.ready;
      rsp_color_in   = rsp_color_ff;
      nan_color_in   = nan_color_ff;
      point_count_in = point_count_ff;
      x_in           = x_ff;
      issue_in       = issue_ff;
      dv_in          = 1'b0;
      chk_idx_in     = chk_idx_ff;
      prev_key_in    = prev_key_ff;
      prev_col_in    = prev_col_ff;
      hi_col_in      = hi_col_ff;
      dk_in          = dk_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      qcnt_in        = qcnt_ff;
      rel_in         = rel_ff;
      ch_in          = ch_ff;
      res_in         = res_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NAN_COLOR:   nan_color_in   = csr_data;
            CSR_POINT_COUNT: point_count_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req && (req_item.command == CMD_COLORIZE)) begin
               if (req_item.sample_is_nan) begin
                  res_in   = nan_color_ff;
                  state_in = ST_OUT;
               end else if (n_use == '0) begin
                  res_in   = gray_color;
                  state_in = ST_OUT;
               end else begin
                  x_in     = req_item.sample;
                  issue_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in   = issue_ff + CW'(1);
               dv_in      = 1'b1;
               chk_idx_in = issue_ff[AW-1:0];
            end
            if (dv_ff) begin
               if (!(rd_key < x_ff)) begin
                  // first key at or above the sample
                  if (chk_idx_ff == '0) begin
                     res_in   = rd_col;
                     state_in = ST_OUT;
                  end else begin
                     hi_col_in = rd_col;
                     ch_in     = '0;
                     if (dx >= dk_s) begin
                        rel_in   = REL_ONE;
                        state_in = ST_BLEND;
                     end else begin
                        dk_in    = dk_s[SAMPLE_W-1:0];
                        rem_in   = dx[SAMPLE_W-1:0];
                        quo_in   = '0;
                        qcnt_in  = QCW'(FRAC_BITS);
                        state_in = ST_DIV;
                     end
                  end
               end else begin
                  prev_key_in = rd_key;
                  prev_col_in = rd_col;
                  // every key below the sample: last point's color
                  if (CW'(chk_idx_ff) == n_last) begin
                     res_in   = rd_col;
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_DIV: begin
            if (q_bit) begin
               rem_in = SAMPLE_W'(rem_2x - {1'b0, dk_ff});
            end else begin
               rem_in = rem_2x[SAMPLE_W-1:0];
            end
            quo_in  = quo_next;
            qcnt_in = qcnt_ff - QCW'(1);
            if (qcnt_ff == QCW'(1)) begin
               rel_in   = {1'b0, quo_next};
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            res_in[{ch_ff, 3'b000} +: CHAN_W] = chan_sum[CHAN_W-1:0];
            ch_in = ch_ff + 2'd1;
            if (ch_ff == 2'd3) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         nan_color_ff   <= '0;
         point_count_ff <= '0;
         dv_ff          <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         nan_color_ff   <= nan_color_in;
         point_count_ff <= point_count_in;
         dv_ff          <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_color_ff <= rsp_color_in;
      x_ff         <= x_in;
      issue_ff     <= issue_in;
      chk_idx_ff   <= chk_idx_in;
      prev_key_ff  <= prev_key_in;
      prev_col_ff  <= prev_col_in;
      hi_col_ff    <= hi_col_in;
      dk_ff        <= dk_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      qcnt_ff      <= qcnt_in;
      rel_ff       <= rel_in;
      ch_ff        <= ch_in;
      res_ff       <= res_in;
   end

endmodule
